/* sv/r_subset_lexer_core_macros.svh */
// Assertion macros for the R-subset lexer core.
// Included by the top level; no other dependencies.
`ifndef R_SUBSET_LEXER_CORE_MACROS_SVH
`define R_SUBSET_LEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSL_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked later than the antecedent.
`define RSL_ASSERT_LATER2(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

/* sv/rsl_pkg.sv */
// Shared types, token class codes, character codes and keyword table
// for the R-subset lexer. No dependencies.
`timescale 1ns / 1ps

package rsl_pkg;

    localparam int CHAR_W    = 8;
    localparam int CLASS_W   = 6;
    localparam int VALUE_W   = 32;
    localparam int LEN_OUT_W = 8;
    localparam int POS_OUT_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [CLASS_W-1:0] t_class;
    typedef logic [CHAR_W-1:0]  t_char;

    // Token class codes
    localparam t_class C_NUM     = 6'd0;
    localparam t_class C_ID      = 6'd1;
    localparam t_class C_KW_BASE = 6'd2;
    localparam t_class C_LPAREN  = 6'd14;
    localparam t_class C_RPAREN  = 6'd15;
    localparam t_class C_SEMI    = 6'd16;
    localparam t_class C_LBRACE  = 6'd17;
    localparam t_class C_COLON   = 6'd18;
    localparam t_class C_RBRACE  = 6'd19;
    localparam t_class C_COMMA   = 6'd20;
    localparam t_class C_ASSIGN  = 6'd21;
    localparam t_class C_EQEQ    = 6'd22;
    localparam t_class C_PLUS    = 6'd23;
    localparam t_class C_MINUS   = 6'd24;
    localparam t_class C_STAR    = 6'd25;
    localparam t_class C_SLASH   = 6'd26;
    localparam t_class C_DOT     = 6'd27;
    localparam t_class C_LT      = 6'd28;
    localparam t_class C_LE      = 6'd29;
    localparam t_class C_GT      = 6'd30;
    localparam t_class C_GE      = 6'd31;
    localparam t_class C_NE      = 6'd32;
    localparam t_class C_AMP     = 6'd33;
    localparam t_class C_BAR     = 6'd34;
    localparam t_class C_ERR     = 6'd35;
    localparam t_class C_END     = 6'd36;

    // Character codes
    localparam t_char CH_NL     = 8'h0A;
    localparam t_char CH_TAB    = 8'h09;
    localparam t_char CH_VT     = 8'h0B;
    localparam t_char CH_FF     = 8'h0C;
    localparam t_char CH_CR     = 8'h0D;
    localparam t_char CH_SPACE  = 8'h20;
    localparam t_char CH_BANG   = 8'h21;
    localparam t_char CH_HASH   = 8'h23;
    localparam t_char CH_AMP    = 8'h26;
    localparam t_char CH_LPAREN = 8'h28;
    localparam t_char CH_RPAREN = 8'h29;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_COMMA  = 8'h2C;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_DOT    = 8'h2E;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_0      = 8'h30;
    localparam t_char CH_9      = 8'h39;
    localparam t_char CH_COLON  = 8'h3A;
    localparam t_char CH_SEMI   = 8'h3B;
    localparam t_char CH_LT     = 8'h3C;
    localparam t_char CH_EQ     = 8'h3D;
    localparam t_char CH_GT     = 8'h3E;
    localparam t_char CH_UA     = 8'h41;
    localparam t_char CH_UZ     = 8'h5A;
    localparam t_char CH_LA     = 8'h61;
    localparam t_char CH_LZ     = 8'h7A;
    localparam t_char CH_LBRACE = 8'h7B;
    localparam t_char CH_BAR    = 8'h7C;
    localparam t_char CH_RBRACE = 8'h7D;
    localparam t_char CASE_OFS  = 8'h20;

    // Keywords, lowercase, first character in the top byte, space padded
    localparam int KW_NUM     = 12;
    localparam int KW_MAX_LEN = 8;
    localparam logic [KW_MAX_LEN*CHAR_W-1:0] KW_TEXT [KW_NUM] = '{
        "if      ", "else    ", "while   ", "for     ",
        "in      ", "repeat  ", "ifelse  ", "function",
        "true    ", "false   ", "break   ", "print   "
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd6, 4'd6, 4'd8, 4'd4, 4'd5, 4'd5, 4'd5
    };

    typedef struct packed {
        t_class                 cls;
        logic [VALUE_W-1:0]     value;
        logic [LEN_OUT_W-1:0]   length;
        logic [POS_OUT_W-1:0]   line;
        logic [POS_OUT_W-1:0]   col;
    } t_token;

    // Results of one item: one or two tokens
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic t_class single_class(input t_char c);
        t_class cls;
        case (c)
            CH_LPAREN: cls = C_LPAREN;
            CH_RPAREN: cls = C_RPAREN;
            CH_SEMI:   cls = C_SEMI;
            CH_LBRACE: cls = C_LBRACE;
            CH_COLON:  cls = C_COLON;
            CH_RBRACE: cls = C_RBRACE;
            CH_COMMA:  cls = C_COMMA;
            CH_PLUS:   cls = C_PLUS;
            CH_STAR:   cls = C_STAR;
            CH_SLASH:  cls = C_SLASH;
            CH_DOT:    cls = C_DOT;
            CH_AMP:    cls = C_AMP;
            CH_BAR:    cls = C_BAR;
            default:   cls = C_ERR;
        endcase
        return cls;
    endfunction

endpackage

/* sv/rsl_ifs.sv */
// Valid/ready channel interfaces for source bytes and tokens.
// Depends on rsl_pkg.
`timescale 1ns / 1ps

interface rsl_in_if import rsl_pkg::*; ();
    logic        valid;
    logic        ready;
    t_char       char_code;
    logic        end_of_input;

    modport source (output valid, char_code, end_of_input, input ready);
    modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface rsl_out_if import rsl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    t_class               token_class;
    logic [VALUE_W-1:0]   number_value;
    logic [LEN_OUT_W-1:0] token_length;
    logic [POS_OUT_W-1:0] line_number;
    logic [POS_OUT_W-1:0] column;
    logic                 last;

    modport source (output valid, token_class, number_value, token_length, line_number,
                    column, last, input ready);
    modport sink   (input valid, token_class, number_value, token_length, line_number,
                    column, last, output ready);
endinterface

/* sv/rsl_front.sv */
// Scanner front end: accepts one source byte per cycle unless the queue is
// full; tracks lexer state, position; pushes completed tokens. Uses rsl_pkg.
`timescale 1ns / 1ps

module rsl_front
    import rsl_pkg::*;
#(
    parameter int KEYWORD_BUF_LEN = 8,
    parameter int MAX_TOKEN_LEN   = 255,
    parameter int POSITION_BITS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rsl_in_if.sink       i_in,
    input  t_qstat       i_qstat,
    output logic         o_push,
    output t_pair        o_pair
);

    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int IDX_W = $clog2(KEYWORD_BUF_LEN);
    localparam int POS_W = POSITION_BITS;

    typedef enum logic [3:0] {
        M_IDLE, M_NUM, M_WORD, M_COMMENT, M_EQ, M_LT, M_GT, M_MINUS, M_BANG
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [LEN_W-1:0]   r_wcnt, n_wcnt;
    logic [VALUE_W-1:0] r_num, n_num;
    logic [POS_W-1:0]   r_line, n_line;
    logic [POS_W-1:0]   r_col, n_col;
    logic [POS_W-1:0]   r_start, n_start;
    t_char              r_chars [KEYWORD_BUF_LEN];

    logic               w_take;
    t_char              w_c, w_lower;
    logic               w_digit, w_alpha, w_blank, w_nl;
    logic [VALUE_W+3:0] w_x10;
    logic [VALUE_W-1:0] w_num_next;
    logic [LEN_W-1:0]   w_wcnt_inc;
    logic               w_wcnt_lt_buf;
    logic [POS_W-1:0]   w_col_inc, w_line_inc;
    t_class             w_kw_cls;
    t_mode              w_id_mode;
    logic               w_id_tok;
    logic               w_fl_v;
    t_token             w_fl_tok, w_id_tok_data;
    logic               w_a_v, w_b_v, w_do_idle;
    t_token             w_b_tok;
    logic               w_chr_we;
    logic [IDX_W-1:0]   w_chr_idx;

    assign i_in.ready = !i_qstat.full;
    assign w_take     = i_in.valid && i_in.ready;
    assign w_c        = i_in.char_code;

    assign w_digit = (w_c >= CH_0) && (w_c <= CH_9);
    assign w_alpha = ((w_c >= CH_LA) && (w_c <= CH_LZ)) || ((w_c >= CH_UA) && (w_c <= CH_UZ));
    assign w_blank = (w_c == CH_SPACE) || (w_c == CH_TAB) || (w_c == CH_VT) ||
                     (w_c == CH_FF) || (w_c == CH_CR);
    assign w_nl    = (w_c == CH_NL);
    assign w_lower = ((w_c >= CH_UA) && (w_c <= CH_UZ)) ? w_c + CASE_OFS : w_c;

    // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, saturating
    assign w_x10 = {1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0}
                 + {{VALUE_W{1'b0}}, w_c[3:0]};
    assign w_num_next = (|w_x10[VALUE_W+3:VALUE_W]) ? '1 : w_x10[VALUE_W-1:0];

    assign w_wcnt_inc    = (r_wcnt != LEN_W'(MAX_TOKEN_LEN)) ? r_wcnt + 1'b1 : r_wcnt;
    assign w_wcnt_lt_buf = {1'b0, r_wcnt} < (LEN_W + 1)'(KEYWORD_BUF_LEN);
    assign w_col_inc     = (&r_col)  ? r_col  : r_col + 1'b1;
    assign w_line_inc    = (&r_line) ? r_line : r_line + 1'b1;

    // Keyword match against the stored lowercase prefix
    always_comb begin
        logic hit;
        w_kw_cls = C_ID;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            hit = (r_wcnt == LEN_W'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if ((i < KW_LEN[k]) &&
                    (r_chars[i] != KW_TEXT[k][(KW_MAX_LEN-1-i)*CHAR_W +: CHAR_W])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                w_kw_cls = C_KW_BASE + CLASS_W'(k);
            end
        end
    end

    // Pending token, emitted when the current run or lookahead ends
    always_comb begin
        w_fl_v         = 1'b1;
        w_fl_tok.cls   = C_ERR;
        w_fl_tok.value = '0;
        w_fl_tok.length = LEN_OUT_W'(1);
        w_fl_tok.line  = POS_OUT_W'(r_line);
        w_fl_tok.col   = POS_OUT_W'(r_start);
        case (r_mode)
            M_NUM: begin
                w_fl_tok.cls    = C_NUM;
                w_fl_tok.value  = r_num;
                w_fl_tok.length = LEN_OUT_W'(r_wcnt);
            end
            M_WORD: begin
                w_fl_tok.cls    = w_kw_cls;
                w_fl_tok.length = LEN_OUT_W'(r_wcnt);
            end
            M_EQ:    w_fl_tok.cls = C_ASSIGN;
            M_LT:    w_fl_tok.cls = C_LT;
            M_GT:    w_fl_tok.cls = C_GT;
            M_MINUS: w_fl_tok.cls = C_MINUS;
            M_BANG:  w_fl_tok.cls = C_ERR;
            default: w_fl_v = 1'b0;
        endcase
    end

    // Classification of a byte seen with no token pending
    always_comb begin
        w_id_mode = M_IDLE;
        w_id_tok  = 1'b0;
        if (w_nl || w_blank) begin
            w_id_mode = M_IDLE;
        end else if (w_digit) begin
            w_id_mode = M_NUM;
        end else if (w_alpha) begin
            w_id_mode = M_WORD;
        end else if (w_c == CH_HASH) begin
            w_id_mode = M_COMMENT;
        end else if (w_c == CH_EQ) begin
            w_id_mode = M_EQ;
        end else if (w_c == CH_LT) begin
            w_id_mode = M_LT;
        end else if (w_c == CH_GT) begin
            w_id_mode = M_GT;
        end else if (w_c == CH_MINUS) begin
            w_id_mode = M_MINUS;
        end else if (w_c == CH_BANG) begin
            w_id_mode = M_BANG;
        end else begin
            w_id_tok = 1'b1;
        end
        w_id_tok_data.cls    = single_class(w_c);
        w_id_tok_data.value  = '0;
        w_id_tok_data.length = LEN_OUT_W'(1);
        w_id_tok_data.line   = POS_OUT_W'(r_line);
        w_id_tok_data.col    = POS_OUT_W'(r_col);
    end

    always_comb begin
        n_mode    = r_mode;
        n_wcnt    = r_wcnt;
        n_num     = r_num;
        n_line    = r_line;
        n_col     = r_col;
        n_start   = r_start;
        w_a_v     = 1'b0;
        w_b_v     = 1'b0;
        w_b_tok   = w_id_tok_data;
        w_do_idle = 1'b0;
        w_chr_we  = 1'b0;
        w_chr_idx = r_wcnt[IDX_W-1:0];

        if (w_take) begin
            if (i_in.end_of_input) begin
                w_a_v          = w_fl_v;
                w_b_v          = 1'b1;
                w_b_tok.cls    = C_END;
                w_b_tok.length = '0;
                w_b_tok.col    = POS_OUT_W'(r_col);
                n_mode         = M_IDLE;
                n_wcnt         = '0;
                n_num          = '0;
                n_line         = POS_W'(1);
                n_col          = POS_W'(1);
                n_start        = POS_W'(1);
            end else begin
                // two-character operators reuse the b slot
                w_b_tok.length = LEN_OUT_W'(2);
                w_b_tok.col    = POS_OUT_W'(r_start);
                case (r_mode)
                    M_NUM: begin
                        if (w_digit) begin
                            n_num  = w_num_next;
                            n_wcnt = w_wcnt_inc;
                            n_col  = w_col_inc;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    M_WORD: begin
                        if (w_digit || w_alpha) begin
                            w_chr_we = w_wcnt_lt_buf;
                            n_wcnt   = w_wcnt_inc;
                            n_col    = w_col_inc;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    M_COMMENT: begin
                        if (w_nl) begin
                            n_line = w_line_inc;
                            n_col  = POS_W'(1);
                            n_mode = M_IDLE;
                        end else begin
                            n_col = w_col_inc;
                        end
                    end
                    M_EQ: begin
                        if (w_c == CH_EQ) begin
                            w_b_v       = 1'b1;
                            w_b_tok.cls = C_EQEQ;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    M_LT: begin
                        if (w_c == CH_MINUS) begin
                            w_b_v       = 1'b1;
                            w_b_tok.cls = C_ASSIGN;
                        end else if (w_c == CH_EQ) begin
                            w_b_v       = 1'b1;
                            w_b_tok.cls = C_LE;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    M_GT: begin
                        if (w_c == CH_EQ) begin
                            w_b_v       = 1'b1;
                            w_b_tok.cls = C_GE;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    M_MINUS: begin
                        if (w_c == CH_GT) begin
                            w_b_v       = 1'b1;
                            w_b_tok.cls = C_ASSIGN;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    M_BANG: begin
                        if (w_c == CH_EQ) begin
                            w_b_v       = 1'b1;
                            w_b_tok.cls = C_NE;
                        end else begin
                            w_do_idle = 1'b1;
                        end
                    end
                    default: w_do_idle = 1'b1;
                endcase

                if (w_b_v) begin
                    n_col  = w_col_inc;
                    n_mode = M_IDLE;
                end

                if (w_do_idle) begin
                    w_a_v   = w_fl_v;
                    w_b_tok = w_id_tok_data;
                    n_mode  = w_id_mode;
                    if (w_nl) begin
                        n_line = w_line_inc;
                        n_col  = POS_W'(1);
                    end else begin
                        w_b_v   = w_id_tok;
                        n_start = r_col;
                        n_col   = w_col_inc;
                        if (w_digit) begin
                            n_num  = VALUE_W'(w_c[3:0]);
                            n_wcnt = LEN_W'(1);
                        end else if (w_alpha) begin
                            w_chr_we  = 1'b1;
                            w_chr_idx = '0;
                            n_wcnt    = LEN_W'(1);
                        end
                    end
                end
            end
        end
    end

    assign o_push      = w_a_v || w_b_v;
    assign o_pair.two  = w_a_v && w_b_v;
    assign o_pair.tok0 = w_a_v ? w_fl_tok : w_b_tok;
    assign o_pair.tok1 = w_b_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_wcnt  <= '0;
            r_num   <= '0;
            r_line  <= POS_W'(1);
            r_col   <= POS_W'(1);
            r_start <= POS_W'(1);
        end else begin
            r_mode  <= n_mode;
            r_wcnt  <= n_wcnt;
            r_num   <= n_num;
            r_line  <= n_line;
            r_col   <= n_col;
            r_start <= n_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_chr_we) begin
            r_chars[w_chr_idx] <= w_lower;
        end
    end

endmodule

/* sv/rsl_queue.sv */
// Short queue of token pairs between the scanner and the output stage.
// Uses rsl_pkg.
`timescale 1ns / 1ps

module rsl_queue
    import rsl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_pair  i_pair,
    input  logic   i_pop,
    output t_pair  o_head,
    output t_qstat o_qstat
);

    t_pair             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_head        = r_mem[r_rp];
    assign o_qstat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_pair;
        end
    end

endmodule

/* sv/rsl_back.sv */
// Output stage: splits queued token pairs into single tokens, marks the
// last token of each item and holds it in the output register. Uses rsl_pkg.
`timescale 1ns / 1ps

module rsl_back
    import rsl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pair     i_head,
    input  t_qstat    i_qstat,
    output logic      o_pop,
    rsl_out_if.source o_out
);

    logic   r_vld;
    logic   r_sel;
    logic   r_last;
    t_token r_tok;
    logic   w_load;

    assign w_load = !r_vld || o_out.ready;
    // a pair entry is released only when its second token is loaded
    assign o_pop  = w_load && !i_qstat.empty && (r_sel || !i_head.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sel <= 1'b0;
        end else if (w_load) begin
            r_vld <= !i_qstat.empty;
            if (!i_qstat.empty) begin
                r_tok  <= r_sel ? i_head.tok1 : i_head.tok0;
                r_last <= r_sel || !i_head.two;
                r_sel  <= !r_sel && i_head.two;
            end
        end
    end

    assign o_out.valid        = r_vld;
    assign o_out.token_class  = r_tok.cls;
    assign o_out.number_value = r_tok.value;
    assign o_out.token_length = r_tok.length;
    assign o_out.line_number  = r_tok.line;
    assign o_out.column       = r_tok.col;
    assign o_out.last         = r_last;

endmodule

/* sv/r_subset_lexer_core.sv */
// A token passes from the scanner through the queue into the output register.
// Throughput: one source byte per cycle while the queue is not full; the output sends
// one token per cycle while ready is high; a 4-entry queue absorbs two-token bytes.
// Reset (synchronous, active low): scanner idle at line 1, column 1, queue and
// output register empty. Depends on rsl_pkg, rsl_ifs, rsl_front/queue/back and the macros.
`timescale 1ns / 1ps
`include "r_subset_lexer_core_macros.svh"

module r_subset_lexer_core
    import rsl_pkg::*;
#(
    parameter int KEYWORD_BUF_LEN = 8,
    parameter int MAX_TOKEN_LEN   = 255,
    parameter int POSITION_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsl_in_if.sink    i_in,
    rsl_out_if.source o_out
);

    logic   w_push;
    logic   w_pop;
    t_pair  w_pair;
    t_pair  w_head;
    t_qstat w_qstat;

    rsl_front #(
        .KEYWORD_BUF_LEN (KEYWORD_BUF_LEN),
        .MAX_TOKEN_LEN   (MAX_TOKEN_LEN),
        .POSITION_BITS   (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_pair  (w_pair)
    );

    rsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pair  (w_pair),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    rsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    `RSL_ASSERT_HOLDS(a_no_overflow, i_clk, i_rst_n, w_push, !w_qstat.full, "queue overflow")
    `RSL_ASSERT_HOLDS(a_no_underflow, i_clk, i_rst_n, w_pop, !w_qstat.empty, "queue underflow")
    `RSL_ASSERT_HOLDS(a_end_is_last, i_clk, i_rst_n,
        o_out.valid && (o_out.token_class == C_END), o_out.last, "end token not last")
    `RSL_ASSERT_LATER2(a_fast_path, i_clk, i_rst_n,
        w_push && w_qstat.empty && !o_out.valid, o_out.valid, "token not presented")

endmodule
